// ----- hw/rtl/sparse_set_swap_remove_pool_unit_defines.svh -----
// ----------------------------------------------------------------------------
// Sparse set pool assertion macros
// Shared concurrent assertion forms used by the pool RTL.
// ----------------------------------------------------------------------------
`ifndef SPARSE_SET_SWAP_REMOVE_POOL_UNIT_DEFINES_SVH
`define SPARSE_SET_SWAP_REMOVE_POOL_UNIT_DEFINES_SVH

// Condition holds at every clock edge out of reset.
`define SSP_ASSERT_ALWAYS(lbl, clk, rst_n, cond, msg) \
  lbl: assert property (@(posedge clk) disable iff (!(rst_n)) (cond)) else $error(msg);

// Antecedent implies consequent in the same cycle.
`define SSP_ASSERT_IMPLY(lbl, clk, rst_n, ante, cons, msg) \
  lbl: assert property (@(posedge clk) disable iff (!(rst_n)) (ante) |-> (cons)) \
    else $error(msg);

`endif

// ----- hw/rtl/ssp_pkg.sv -----
// ----------------------------------------------------------------------------
// Sparse set pool package
// Operation kinds, result status codes, sequencer states and control structs.
// ----------------------------------------------------------------------------
package ssp_pkg;

  typedef enum logic [1:0] {
    KIND_ADD      = 2'd0,
    KIND_GET      = 2'd1,
    KIND_REMOVE   = 2'd2,
    KIND_READ_ROW = 2'd3
  } ssp_kind_e;

  typedef enum logic [2:0] {
    STAT_OK      = 3'd0,
    STAT_PRESENT = 3'd1,
    STAT_ABSENT  = 3'd2,
    STAT_FULL    = 3'd3,
    STAT_BEYOND  = 3'd4
  } ssp_status_e;

  typedef enum logic [2:0] {
    S_INIT,
    S_IDLE,
    S_LOOKUP,
    S_FETCH,
    S_RM_LAST,
    S_RESP
  } ssp_state_e;

  typedef struct packed {
    logic en;
    logic we;
  } mem_cmd_t;

  typedef struct packed {
    logic        load;
    ssp_status_e status;
  } res_ctl_t;

endpackage

// ----- hw/rtl/ssp_if.sv -----
// ----------------------------------------------------------------------------
// Sparse set pool channel interfaces
// Request and response channels with valid/ready handshake.
// ----------------------------------------------------------------------------
interface ssp_in_if;
  logic        valid;
  logic        ready;
  logic [1:0]  kind;
  logic [9:0]  object_index;
  logic [9:0]  row_index;
  logic [31:0] value;
  logic        value_given;

  modport source (output valid, kind, object_index, row_index, value, value_given,
                  input ready);
  modport sink (input valid, kind, object_index, row_index, value, value_given,
                output ready);
endinterface

interface ssp_out_if;
  logic        valid;
  logic        ready;
  logic [2:0]  status;
  logic [31:0] value_res;
  logic [9:0]  row;
  logic [9:0]  owner_index;
  logic [10:0] item_count;

  modport source (output valid, status, value_res, row, owner_index, item_count,
                  input ready);
  modport sink (input valid, status, value_res, row, owner_index, item_count,
                output ready);
endinterface

// ----- hw/rtl/ssp_ram.sv -----
// ----------------------------------------------------------------------------
// Sparse set pool RAM
// Single-port synchronous RAM, one access per cycle, registered read data.
// ----------------------------------------------------------------------------
module ssp_ram #(
  parameter int WIDTH = 32,
  parameter int DEPTH = 1024
) (
  input  logic                     clk_i,
  input  logic                     en_i,
  input  logic                     we_i,
  input  logic [$clog2(DEPTH)-1:0] addr_i,
  input  logic [WIDTH-1:0]         wdata_i,
  output logic [WIDTH-1:0]         rdata_o
);

  logic [WIDTH-1:0] mem_q [DEPTH];
  logic [WIDTH-1:0] rdata_q;

  always_ff @(posedge clk_i) begin
    if (en_i) begin
      if (we_i) begin
        mem_q[addr_i] <= wdata_i;
      end else begin
        rdata_q <= mem_q[addr_i];
      end
    end
  end

  assign rdata_o = rdata_q;

endmodule

// ----- hw/rtl/ssp_ctrl.sv -----
// ----------------------------------------------------------------------------
// Sparse set pool sequencer
// Walks each request through row map and dense store accesses, keeps the
// packed count and runs the row map clear after reset.
// ----------------------------------------------------------------------------
module ssp_ctrl #(
  parameter int MAX_OBJECTS = 1024,
  parameter int VALUE_BITS  = 32,
  localparam int IdxW = $clog2(MAX_OBJECTS),
  localparam int CntW = $clog2(MAX_OBJECTS + 1),
  localparam int EntW = VALUE_BITS + IdxW
) (
  input  logic                clk_i,
  input  logic                rst_ni,
  ssp_in_if.sink              in_i,
  input  logic                out_free_i,
  output ssp_pkg::res_ctl_t   res_ctl_o,
  output logic [VALUE_BITS-1:0] res_value_o,
  output logic [IdxW-1:0]     res_row_o,
  output logic [IdxW-1:0]     res_owner_o,
  output logic [CntW-1:0]     count_o,
  output ssp_pkg::mem_cmd_t   dense_cmd_o,
  output logic [IdxW-1:0]     dense_addr_o,
  output logic [EntW-1:0]     dense_wdata_o,
  input  logic [EntW-1:0]     dense_rdata_i,
  output ssp_pkg::mem_cmd_t   map_cmd_o,
  output logic [IdxW-1:0]     map_addr_o,
  output logic [CntW-1:0]     map_wdata_o,
  input  logic [CntW-1:0]     map_rdata_i
);

  localparam logic [CntW-1:0] RowNone = CntW'(MAX_OBJECTS);
  localparam logic [IdxW-1:0] LastIdx = IdxW'(MAX_OBJECTS - 1);

  ssp_pkg::ssp_state_e  state_q, state_d;
  logic [CntW-1:0]      count_q, count_d;
  logic [IdxW-1:0]      init_q, init_d;

  ssp_pkg::ssp_kind_e   kind_q, kind_d;
  logic [IdxW-1:0]      obj_q, obj_d;
  logic [VALUE_BITS-1:0] newval_q, newval_d;
  logic [IdxW-1:0]      row_q, row_d;
  ssp_pkg::ssp_status_e res_status_q, res_status_d;
  logic [VALUE_BITS-1:0] res_value_q, res_value_d;
  logic [IdxW-1:0]      res_row_q, res_row_d;
  logic [IdxW-1:0]      res_owner_q, res_owner_d;

  logic                 take;
  ssp_pkg::ssp_kind_e   in_kind;
  logic [16:0]          obj_ext, rix_ext;
  logic [63:0]          val_ext;
  logic [IdxW-1:0]      obj_idx, rix_idx, last_idx;
  logic                 obj_ok, rix_ok, present, full, row_is_last;
  logic [VALUE_BITS-1:0] ent_value;
  logic [IdxW-1:0]      ent_owner;

  assign in_i.ready = (state_q == ssp_pkg::S_IDLE) ||
                      ((state_q == ssp_pkg::S_RESP) && out_free_i);
  assign take       = in_i.valid && in_i.ready;
  assign in_kind    = ssp_pkg::ssp_kind_e'(in_i.kind);

  assign obj_ext  = 17'(in_i.object_index);
  assign rix_ext  = 17'(in_i.row_index);
  assign val_ext  = 64'(in_i.value);
  assign obj_idx  = obj_ext[IdxW-1:0];
  assign rix_idx  = rix_ext[IdxW-1:0];
  assign obj_ok   = obj_ext < 17'(MAX_OBJECTS);
  assign rix_ok   = rix_ext < 17'(count_q);

  assign present     = map_rdata_i < count_q;
  assign full        = count_q == RowNone;
  assign last_idx    = IdxW'(count_q - 1'b1);
  assign row_is_last = row_q == last_idx;
  assign ent_value   = dense_rdata_i[VALUE_BITS-1:0];
  assign ent_owner   = dense_rdata_i[EntW-1:VALUE_BITS];

  // Next state
  always_comb begin
    state_d = state_q;
    unique case (state_q) inside
      ssp_pkg::S_INIT: begin
        if (init_q == LastIdx) state_d = ssp_pkg::S_IDLE;
      end
      ssp_pkg::S_IDLE, ssp_pkg::S_RESP: begin
        if (take) begin
          if (in_kind == ssp_pkg::KIND_READ_ROW) begin
            state_d = rix_ok ? ssp_pkg::S_FETCH : ssp_pkg::S_RESP;
          end else begin
            state_d = obj_ok ? ssp_pkg::S_LOOKUP : ssp_pkg::S_RESP;
          end
        end else if (state_q == ssp_pkg::S_RESP && out_free_i) begin
          state_d = ssp_pkg::S_IDLE;
        end
      end
      ssp_pkg::S_LOOKUP: begin
        state_d = (present && kind_q != ssp_pkg::KIND_ADD) ||
                  (present && kind_q == ssp_pkg::KIND_ADD) ?
                  ssp_pkg::S_FETCH : ssp_pkg::S_RESP;
      end
      ssp_pkg::S_FETCH: begin
        state_d = (kind_q == ssp_pkg::KIND_REMOVE) ? ssp_pkg::S_RM_LAST : ssp_pkg::S_RESP;
      end
      ssp_pkg::S_RM_LAST: state_d = ssp_pkg::S_RESP;
      default:            state_d = ssp_pkg::S_IDLE;
    endcase
  end

  // Memory commands and datapath
  always_comb begin
    count_d       = count_q;
    init_d        = init_q;
    kind_d        = kind_q;
    obj_d         = obj_q;
    newval_d      = newval_q;
    row_d         = row_q;
    res_status_d  = res_status_q;
    res_value_d   = res_value_q;
    res_row_d     = res_row_q;
    res_owner_d   = res_owner_q;
    dense_cmd_o   = '0;
    dense_addr_o  = '0;
    dense_wdata_o = '0;
    map_cmd_o     = '0;
    map_addr_o    = '0;
    map_wdata_o   = '0;
    res_ctl_o.load   = 1'b0;
    res_ctl_o.status = res_status_q;

    unique case (state_q) inside
      ssp_pkg::S_INIT: begin
        map_cmd_o   = '{en: 1'b1, we: 1'b1};
        map_addr_o  = init_q;
        map_wdata_o = RowNone;
        init_d      = init_q + 1'b1;
      end
      ssp_pkg::S_IDLE, ssp_pkg::S_RESP: begin
        res_ctl_o.load = (state_q == ssp_pkg::S_RESP) && out_free_i;
        if (take) begin
          kind_d   = in_kind;
          obj_d    = obj_idx;
          newval_d = in_i.value_given ? val_ext[VALUE_BITS-1:0] : '0;
          row_d    = rix_idx;
          if (in_kind == ssp_pkg::KIND_READ_ROW) begin
            if (rix_ok) begin
              dense_cmd_o  = '{en: 1'b1, we: 1'b0};
              dense_addr_o = rix_idx;
            end else begin
              res_status_d = ssp_pkg::STAT_BEYOND;
              res_value_d  = '0;
              res_row_d    = '0;
              res_owner_d  = '0;
            end
          end else if (obj_ok) begin
            map_cmd_o  = '{en: 1'b1, we: 1'b0};
            map_addr_o = obj_idx;
          end else begin
            res_status_d = ssp_pkg::STAT_ABSENT;
            res_value_d  = '0;
            res_row_d    = '0;
            res_owner_d  = '0;
          end
        end
      end
      ssp_pkg::S_LOOKUP: begin
        row_d = map_rdata_i[IdxW-1:0];
        if (present) begin
          dense_cmd_o  = '{en: 1'b1, we: 1'b0};
          dense_addr_o = map_rdata_i[IdxW-1:0];
        end else if (kind_q != ssp_pkg::KIND_ADD) begin
          res_status_d = ssp_pkg::STAT_ABSENT;
          res_value_d  = '0;
          res_row_d    = '0;
          res_owner_d  = '0;
        end else if (full) begin
          res_status_d = ssp_pkg::STAT_FULL;
          res_value_d  = '0;
          res_row_d    = '0;
          res_owner_d  = '0;
        end else begin
          // append at the end of the packed rows
          dense_cmd_o   = '{en: 1'b1, we: 1'b1};
          dense_addr_o  = count_q[IdxW-1:0];
          dense_wdata_o = {obj_q, newval_q};
          map_cmd_o     = '{en: 1'b1, we: 1'b1};
          map_addr_o    = obj_q;
          map_wdata_o   = count_q;
          count_d       = count_q + 1'b1;
          res_status_d  = ssp_pkg::STAT_OK;
          res_value_d   = newval_q;
          res_row_d     = count_q[IdxW-1:0];
          res_owner_d   = obj_q;
        end
      end
      ssp_pkg::S_FETCH: begin
        res_value_d = ent_value;
        res_row_d   = row_q;
        res_owner_d = obj_q;
        case (kind_q)
          ssp_pkg::KIND_READ_ROW: begin
            res_status_d = ssp_pkg::STAT_OK;
            res_owner_d  = ent_owner;
          end
          ssp_pkg::KIND_ADD: res_status_d = ssp_pkg::STAT_PRESENT;
          ssp_pkg::KIND_REMOVE: begin
            res_status_d = ssp_pkg::STAT_OK;
            map_cmd_o    = '{en: 1'b1, we: 1'b1};
            map_addr_o   = obj_q;
            map_wdata_o  = RowNone;
            dense_cmd_o  = '{en: 1'b1, we: 1'b0};
            dense_addr_o = last_idx;
          end
          default: res_status_d = ssp_pkg::STAT_OK;
        endcase
      end
      ssp_pkg::S_RM_LAST: begin
        // unless the hole is the last row, move the last row into it and repoint its owner; shrink the count
        if (!row_is_last) begin
          dense_cmd_o   = '{en: 1'b1, we: 1'b1};
          dense_addr_o  = row_q;
          dense_wdata_o = dense_rdata_i;
          map_cmd_o     = '{en: 1'b1, we: 1'b1};
          map_addr_o    = ent_owner;
          map_wdata_o   = CntW'(row_q);
        end
        count_d = count_q - 1'b1;
      end
      default: ;
    endcase
  end

  always_ff @(posedge clk_i or negedge rst_ni) begin
    if (!rst_ni) begin
      state_q <= ssp_pkg::S_INIT;
      count_q <= '0;
      init_q  <= '0;
    end else begin
      state_q <= state_d;
      count_q <= count_d;
      init_q  <= init_d;
    end
  end

  always_ff @(posedge clk_i) begin
    kind_q       <= kind_d;
    obj_q        <= obj_d;
    newval_q     <= newval_d;
    row_q        <= row_d;
    res_status_q <= res_status_d;
    res_value_q  <= res_value_d;
    res_row_q    <= res_row_d;
    res_owner_q  <= res_owner_d;
  end

  assign res_value_o = res_value_q;
  assign res_row_o   = res_row_q;
  assign res_owner_o = res_owner_q;
  assign count_o     = count_q;

endmodule

// ----- hw/rtl/sparse_set_swap_remove_pool_unit.sv -----
// ----------------------------------------------------------------------------
// Sparse set swap-remove pool
// Component pool with packed value/owner rows and a per-object row map.
// ----------------------------------------------------------------------------
//  channel | dir | fields
//  in_i    | in  | kind, object_index, row_index, value, value_given
//  out_o   | out | status, value_res, row, owner_index, item_count
//
// Request path: a row read beyond the count or an object out of range goes
// straight to the response; a row read in range fetches its dense row; other
// requests look up the row map, a present object then has its dense row
// fetched, and a remove also moves the last row into the hole.
// After reset the row map is cleared entry by entry, with in_i.ready low.
// A new request is taken while the previous result waits in the output
// register; the block holds its result only when that register is still full.
`include "sparse_set_swap_remove_pool_unit_defines.svh"

module sparse_set_swap_remove_pool_unit #(
  parameter int MAX_OBJECTS = 1024,
  parameter int VALUE_BITS  = 32
) (
  input  logic    clk_i,
  input  logic    rst_ni,
  ssp_in_if.sink  in_i,
  ssp_out_if.source out_o
);

  localparam int IdxW = $clog2(MAX_OBJECTS);
  localparam int CntW = $clog2(MAX_OBJECTS + 1);
  localparam int EntW = VALUE_BITS + IdxW;

  ssp_pkg::res_ctl_t   res_ctl;
  logic [VALUE_BITS-1:0] res_value;
  logic [IdxW-1:0]     res_row, res_owner;
  logic [CntW-1:0]     count;
  ssp_pkg::mem_cmd_t   dense_cmd, map_cmd;
  logic [IdxW-1:0]     dense_addr, map_addr;
  logic [EntW-1:0]     dense_wdata, dense_rdata;
  logic [CntW-1:0]     map_wdata, map_rdata;
  logic                out_free;

  logic                out_valid_q, out_valid_d;
  logic [2:0]          out_status_q;
  logic [31:0]         out_value_q;
  logic [9:0]          out_row_q, out_owner_q;
  logic [10:0]         out_count_q;
  logic [63:0]         value_ext;
  logic [16:0]         row_ext, owner_ext, count_ext;

  ssp_ctrl #(
    .MAX_OBJECTS (MAX_OBJECTS),
    .VALUE_BITS  (VALUE_BITS)
  ) u_ctrl (
    .clk_i         (clk_i),
    .rst_ni        (rst_ni),
    .in_i          (in_i),
    .out_free_i    (out_free),
    .res_ctl_o     (res_ctl),
    .res_value_o   (res_value),
    .res_row_o     (res_row),
    .res_owner_o   (res_owner),
    .count_o       (count),
    .dense_cmd_o   (dense_cmd),
    .dense_addr_o  (dense_addr),
    .dense_wdata_o (dense_wdata),
    .dense_rdata_i (dense_rdata),
    .map_cmd_o     (map_cmd),
    .map_addr_o    (map_addr),
    .map_wdata_o   (map_wdata),
    .map_rdata_i   (map_rdata)
  );

  // packed rows: {owner, value}
  ssp_ram #(
    .WIDTH (EntW),
    .DEPTH (MAX_OBJECTS)
  ) u_dense_ram (
    .clk_i   (clk_i),
    .en_i    (dense_cmd.en),
    .we_i    (dense_cmd.we),
    .addr_i  (dense_addr),
    .wdata_i (dense_wdata),
    .rdata_o (dense_rdata)
  );

  ssp_ram #(
    .WIDTH (CntW),
    .DEPTH (MAX_OBJECTS)
  ) u_map_ram (
    .clk_i   (clk_i),
    .en_i    (map_cmd.en),
    .we_i    (map_cmd.we),
    .addr_i  (map_addr),
    .wdata_i (map_wdata),
    .rdata_o (map_rdata)
  );

  assign out_free  = !out_valid_q || out_o.ready;
  assign value_ext = 64'(res_value);
  assign row_ext   = 17'(res_row);
  assign owner_ext = 17'(res_owner);
  assign count_ext = 17'(count);

  always_comb begin
    out_valid_d = out_valid_q;
    if (res_ctl.load) begin
      out_valid_d = 1'b1;
    end else if (out_o.ready) begin
      out_valid_d = 1'b0;
    end
  end

  always_ff @(posedge clk_i or negedge rst_ni) begin
    if (!rst_ni) begin
      out_valid_q <= 1'b0;
    end else begin
      out_valid_q <= out_valid_d;
    end
  end

  always_ff @(posedge clk_i) begin
    if (res_ctl.load) begin
      out_status_q <= res_ctl.status;
      out_value_q  <= value_ext[31:0];
      out_row_q    <= row_ext[9:0];
      out_owner_q  <= owner_ext[9:0];
      out_count_q  <= count_ext[10:0];
    end
  end

  assign out_o.valid       = out_valid_q;
  assign out_o.status      = out_status_q;
  assign out_o.value_res   = out_value_q;
  assign out_o.row         = out_row_q;
  assign out_o.owner_index = out_owner_q;
  assign out_o.item_count  = out_count_q;

  `SSP_ASSERT_IMPLY(a_load_into_free, clk_i, rst_ni, res_ctl.load, out_free, "result overwrites a pending transfer")
  `SSP_ASSERT_IMPLY(a_count_step, clk_i, rst_ni, count != $past(count), (count == $past(count) + 1'b1) || (count == $past(count) - 1'b1), "packed count jumped")
  `SSP_ASSERT_IMPLY(a_full_at_cap, clk_i, rst_ni, res_ctl.load && (res_ctl.status == ssp_pkg::STAT_FULL), count == CntW'(MAX_OBJECTS), "full reported below capacity")
  `SSP_ASSERT_ALWAYS(a_count_max, clk_i, rst_ni, count <= CntW'(MAX_OBJECTS), "packed count above capacity")

endmodule
